// ----- hw/rtl/vm_numeric_type_cast_macros.svh -----
// Assertion macros shared by the numeric type cast RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef VM_NUMERIC_TYPE_CAST_MACROS_SVH
`define VM_NUMERIC_TYPE_CAST_MACROS_SVH

// Implication check, synchronous reset disables it
`define VNC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define VNC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/vnc_pkg.sv -----
// Package for the numeric type cast unit: type codes and the stage struct.
// Depends on nothing.
package vnc_pkg;

  typedef enum logic [2:0] {
    TY_BYTE   = 3'd0,
    TY_SHORT  = 3'd1,
    TY_CHAR   = 3'd2,
    TY_HALF   = 3'd3,
    TY_INT    = 3'd4,
    TY_FLOAT  = 3'd5,
    TY_LONG   = 3'd6,
    TY_DOUBLE = 3'd7
  } ty_t;

  // Operation picked in the first stage
  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_ERR   = 3'd1,
    OP_FLT32 = 3'd2,
    OP_FLT64 = 3'd3,
    OP_MASK  = 3'd4
  } op_t;

  // Normalised integer handed from the front end to the rounding stage
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        sign;
    logic        zero;
    logic [5:0]  msb;     // position of leading one
    logic [63:0] mant;    // magnitude, leading one at bit 63
    logic [63:0] passv;   // result for non-float ops
  } norm_t;

endpackage

// ----- hw/rtl/vnc_round.sv -----
// Rounding and packing stage pair: normalised magnitude to float32/float64; other ops pass passv through.
// Depends on vnc_pkg and the assertion macro header.
`include "vm_numeric_type_cast_macros.svh"
module vnc_round
  import vnc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  norm_t       nin,
  output logic        valid,
  output logic [63:0] bits
);

  // Stage A: round-to-nearest-even increments
  logic        a_valid;
  op_t         a_op;
  logic        a_sign, a_zero;
  logic [5:0]  a_msb;
  logic [63:0] a_passv;
  logic [24:0] a_m32;  // 24-bit mantissa with carry
  logic [53:0] a_m64;

  logic        g32, s32, g64, s64;
  logic [23:0] t32;
  logic [52:0] t64;
  logic        inc32, inc64;

  always_comb begin
    t32   = nin.mant[63:40];
    g32   = nin.mant[39];
    s32   = |nin.mant[38:0];
    inc32 = g32 & (s32 | t32[0]);
    t64   = nin.mant[63:11];
    g64   = nin.mant[10];
    s64   = |nin.mant[9:0];
    inc64 = g64 & (s64 | t64[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= nin.valid;
    end
    a_op    <= nin.op;
    a_sign  <= nin.sign;
    a_zero  <= nin.zero;
    a_msb   <= nin.msb;
    a_passv <= nin.passv;
    a_m32   <= {1'b0, t32} + {24'd0, inc32};
    a_m64   <= {1'b0, t64} + {53'd0, inc64};
  end

  // Stage B: exponent adjust and field packing
  logic [7:0]  e32;
  logic [10:0] e64;
  logic [22:0] f32;
  logic [51:0] f64;
  logic [63:0] bits_next;

  always_comb begin
    e32 = 8'd127 + {2'b00, a_msb} + {7'd0, a_m32[24]};
    e64 = 11'd1023 + {5'd0, a_msb} + {10'd0, a_m64[53]};
    f32 = a_m32[24] ? a_m32[23:1] : a_m32[22:0];
    f64 = a_m64[53] ? a_m64[52:1] : a_m64[51:0];
    case (a_op)
      OP_FLT32: bits_next = a_zero ? 64'd0 : {32'd0, a_sign, e32, f32};
      OP_FLT64: bits_next = a_zero ? 64'd0 : {a_sign, e64, f64};
      default:  bits_next = a_passv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= a_valid;
    end
    bits <= bits_next;
  end

  // Checks
  `VNC_ASSERT_NXT(a_vld_follow, clk, rst, nin.valid, a_valid, "stage A lost a request")
  `VNC_ASSERT_NXT(b_vld_follow, clk, rst, a_valid, valid, "stage B lost a request")
  `VNC_ASSERT_IMP(f32_hi_zero, clk, rst, valid && $past(a_op) == OP_FLT32,
                  bits[63:32] == 32'd0, "float32 result not zero-extended")

endmodule

// ----- hw/rtl/vm_numeric_type_cast.sv -----
// Top level of the numeric type cast unit: decode/magnitude and normalise stages feeding vnc_round.
// Depends on vnc_pkg, vnc_round and the assertion macro header.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  request   | start / busy         | raw_value, source_type, target_type
//  result    | done (strobe)        | converted_bits, cast_error
//
// Four register stages: decode/magnitude, leading-one shift, round, pack.
// One request per cycle; results leave the pack stage in request order.
// busy is tied low: the receiver cannot stall, so nothing backs up.
// Synchronous reset clears all valid bits; payload registers are not reset.
`include "vm_numeric_type_cast_macros.svh"
module vm_numeric_type_cast
  import vnc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] raw_value,
  input  logic [2:0]  source_type,
  input  logic [2:0]  target_type,
  output logic        done,
  output logic [63:0] converted_bits,
  output logic        cast_error
);

  assign busy = 1'b0;

  // Stage 1: decode the pair, take the magnitude
  logic        s1_valid, s1_sign, s1_err;
  op_t         s1_op;
  logic [63:0] s1_mag, s1_passv;

  logic        req;
  logic [63:0] sv;
  op_t         op_next;
  logic [63:0] pv_next;
  logic        sgn_next;

  assign req = start & ~busy;

  always_comb begin
    sv = (source_type == TY_INT) ? {{32{raw_value[31]}}, raw_value[31:0]} : raw_value;
    sgn_next = sv[63];
    op_next = OP_ERR;
    pv_next = 64'd0;
    if (source_type == target_type) begin
      op_next = OP_PASS;
      pv_next = raw_value;
    end else if (target_type == TY_BYTE) begin
      op_next = OP_PASS;
      pv_next = {56'd0, raw_value[7:0]};
    end else if (source_type == TY_INT || source_type == TY_LONG) begin
      case (target_type)
        TY_SHORT:  begin op_next = OP_MASK; pv_next = {48'd0, sv[15:0]}; end
        TY_INT:    begin op_next = OP_MASK; pv_next = {32'd0, sv[31:0]}; end
        TY_LONG:   begin op_next = OP_MASK; pv_next = sv; end
        TY_FLOAT:  op_next = OP_FLT32;
        TY_DOUBLE: op_next = OP_FLT64;
        default:   op_next = OP_ERR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req;
    end
    s1_op    <= op_next;
    s1_err   <= (op_next == OP_ERR);
    s1_sign  <= sgn_next;
    s1_mag   <= sgn_next ? (~sv + 64'd1) : sv;
    s1_passv <= pv_next;
  end

  // Stage 2: leading-one search and normalising shift
  logic [5:0]  lz;
  logic        found;
  norm_t       s2_next;
  logic        s2_err;
  norm_t       s2;

  always_comb begin
    lz = 6'd0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && s1_mag[i]) begin
        lz = 6'(i);
        found = 1'b1;
      end
    end
    s2_next.valid = s1_valid;
    s2_next.op    = s1_op;
    s2_next.sign  = s1_sign;
    s2_next.zero  = ~found;
    s2_next.msb   = lz;
    s2_next.mant  = s1_mag << (6'd63 - lz);
    s2_next.passv = s1_passv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s2_next.valid;
    end
    s2.op    <= s2_next.op;
    s2.sign  <= s2_next.sign;
    s2.zero  <= s2_next.zero;
    s2.msb   <= s2_next.msb;
    s2.mant  <= s2_next.mant;
    s2.passv <= s2_next.passv;
    s2_err   <= s1_err;
  end

  // Stages 3 and 4: round and pack
  logic e3, e4;
  always_ff @(posedge clk) begin
    e3 <= s2_err;
    e4 <= e3;
  end

  vnc_round u_round (
    .clk   (clk),
    .rst   (rst),
    .nin   (s2),
    .valid (done),
    .bits  (converted_bits)
  );

  assign cast_error = e4;

  // Checks
  `VNC_ASSERT_IMP(err_zero, clk, rst, done && cast_error, converted_bits == 64'd0,
                  "error result not zero")
  `VNC_ASSERT_NXT(s1_take, clk, rst, start, s1_valid, "request not captured")
  `VNC_ASSERT_IMP(never_busy, clk, rst, 1'b1, !busy, "unit stalled")

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for vm_numeric_type_cast: directed and random type conversions,
// checked against an in-bench predictor. Depends on vnc_pkg and the RTL top.
`timescale 1ns / 1ps
module testbench;
  import vnc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [63:0] bits;
    logic        err;
  } cast_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] raw_value;
  logic [2:0]  source_type;
  logic [2:0]  target_type;
  logic        done;
  logic [63:0] converted_bits;
  logic        cast_error;

  cast_result_t pending_casts[$];
  int           mismatches;
  int           cycles;

  vm_numeric_type_cast dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_value(raw_value), .source_type(source_type), .target_type(target_type),
    .done(done), .converted_bits(converted_bits), .cast_error(cast_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Integer to float conversion; float32 is rounded bit by bit (nearest even)
  function automatic logic [63:0] int_to_float(logic signed [63:0] s, bit dbl);
    real         r;
    logic [63:0] mag;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    logic        sgn;
    int          p;
    int          sh;
    logic [7:0]  ex;
    r = real'(s);
    if (dbl) return $realtobits(r);
    sgn = s[63];
    mag = sgn ? (~s + 64'd1) : s;
    if (mag == 64'd0) return 64'd0;
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) p = i;
    end
    if (p <= 23) begin
      keep = mag << (23 - p);
    end else begin
      sh   = p - 23;
      keep = mag >> sh;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      if (keep[24]) begin
        keep = keep >> 1;
        p    = p + 1;
      end
    end
    ex = 8'(127 + p);
    return {32'd0, sgn, ex, keep[22:0]};
  endfunction

  function automatic cast_result_t predict_cast(logic [63:0] raw, ty_t src, ty_t dst);
    cast_result_t      r;
    logic [63:0]       ext;
    logic signed [63:0] s;
    r.bits = '0;
    r.err  = 1'b0;
    if (src == dst) begin
      r.bits = raw;
    end else if (dst == TY_BYTE) begin
      r.bits = {56'd0, raw[7:0]};
    end else if (src == TY_INT || src == TY_LONG) begin
      ext = (src == TY_INT) ? {{32{raw[31]}}, raw[31:0]} : raw;
      s   = ext;
      case (dst)
        TY_SHORT:  r.bits = {48'd0, ext[15:0]};
        TY_INT:    r.bits = {32'd0, ext[31:0]};
        TY_LONG:   r.bits = ext;
        TY_FLOAT:  r.bits = int_to_float(s, 1'b0);
        TY_DOUBLE: r.bits = int_to_float(s, 1'b1);
        default:   r.err = 1'b1;
      endcase
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Result checker and run limit
  always @(posedge clk) begin
    cast_result_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && done) begin
      if (pending_casts.size() == 0) begin
        report_mismatch("unexpected result", converted_bits, 64'd0);
      end else begin
        e = pending_casts.pop_front();
        if (converted_bits !== e.bits) report_mismatch("converted_bits", converted_bits, e.bits);
        if (cast_error !== e.err) begin
          report_mismatch("cast_error", {63'd0, cast_error}, {63'd0, e.err});
        end
      end
    end
  end

  // Send one request; burst gaps come from the caller
  task automatic send_request(logic [63:0] raw, ty_t src, ty_t dst);
    start       <= 1'b1;
    raw_value   <= raw;
    source_type <= src;
    target_type <= dst;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_casts.push_back(predict_cast(raw, src, dst));
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [63:0] random_raw();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = {{32{v[31]}}, v[31:0]};
      1: v = 64'(signed'(v[15:0]));
      2: v = v >> $urandom_range(0, 63);
      3: v = v | 64'h8000_0000_0000_0000;
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_extremes();
    logic [63:0] vals[8];
    vals = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
             64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_8000_0000,
             64'hDEAD_BEEF_7FFF_FFFF, 64'h0000_0000_0100_0001, 64'h0020_0000_0000_0001};
    foreach (vals[i]) begin
      send_request(vals[i], TY_INT, TY_FLOAT);
      send_request(vals[i], TY_LONG, TY_FLOAT);
    end
    send_request(64'h0123_4567_89AB_CDEF, TY_HALF, TY_HALF);
    send_request(64'h0123_4567_89AB_CDEF, TY_DOUBLE, TY_BYTE);
    send_request(64'h0123_4567_89AB_CDEF, TY_FLOAT, TY_INT);
    send_request(64'hFFFF_FFFF_8000_0000, TY_INT, TY_LONG);
    idle_gap(1);
  endtask

  // Every source/destination pair once
  task automatic test_all_pairs();
    for (int s = 0; s < 8; s++)
      for (int d = 0; d < 8; d++)
        send_request(random_raw(), ty_t'(s), ty_t'(d));
    idle_gap(1);
  endtask

  task automatic test_random_bursts(int count);
    ty_t src, dst;
    int  sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 3) != 0) begin
          src = $urandom_range(0, 1) ? TY_INT : TY_LONG;
          dst = ty_t'($urandom_range(0, 7));
        end else begin
          src = ty_t'($urandom_range(0, 7));
          dst = ty_t'($urandom_range(0, 7));
        end
        send_request(random_raw(), src, dst);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    idle_gap(1);
  endtask

  initial begin
    mismatches  = 0;
    cycles      = 0;
    rst         = 1'b1;
    start       = 1'b0;
    raw_value   = '0;
    source_type = '0;
    target_type = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_all_pairs();
    test_random_bursts(420);
    while (pending_casts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/vnc_pkg.sv
hw/rtl/vnc_round.sv
hw/rtl/vm_numeric_type_cast.sv
tb/sv/testbench.sv
